// ===== rtl/wfba_pkg.sv =====
// Package for the worst-fit block allocator.
// Holds table sizes, field widths and command codes; no dependencies.
package wfba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = 5;
	localparam int DATA_W     = ((IDX_W + SIZE_BITS + 7) / 8) * 8;
	localparam int PAD_W      = DATA_W - IDX_W - SIZE_BITS;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

endpackage

// ===== rtl/worst_fit_block_allocator_top.sv =====
// Top level of the worst-fit block allocator: free-size table, scan sequencer
// and output register. Depends on wfba_pkg.
//
// Channel  | Direction | Handshake          | Contents
// ---------+-----------+--------------------+-------------------------------------------
// s_*      | in        | s_tvalid/s_tready  | tuser: command; tdata: block_index,
//          |           |                    | size_value; tlast: final_request
// m_*      | out       | m_tvalid/m_tready  | tuser: granted; tdata: chosen_block,
//          |           |                    | remaining_size; tlast: batch_end
// cfg_*    | in        | cfg_we             | cfg_wdata: block_count
//
// A load item goes from acceptance straight to the response state; an allocate
// item first passes through the scan, which visits one table entry per cycle
// through a single compare unit. A stalled output holds the item in the response
// state. The input is not ready again until the result has entered the output
// register, but a result may wait there while the next item is taken.
// Reset clears the whole table to zero at once and sets block_count to 16.
module worst_fit_block_allocator_top
	import wfba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [3:0] block_index, [19:4] size_value, rest zero
	input  logic              s_tuser,   // [0] command
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [3:0] chosen_block, [19:4] remaining_size, rest zero
	output logic              m_tuser,   // [0] granted
	output logic              m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     block_count_q;
	logic [SIZE_BITS-1:0] table_q [NUM_BLOCKS];

	// Latched item.
	logic                 cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 last_q;

	// Scan state: the running best candidate.
	logic [IDX_W-1:0]     scan_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_val_q;

	// Output register.
	logic                 m_tvalid_q;
	logic                 m_granted_q;
	logic [IDX_W-1:0]     m_idx_q;
	logic [SIZE_BITS-1:0] m_size_q;
	logic                 m_last_q;

	logic [IDX_W-1:0]     in_idx;
	logic [SIZE_BITS-1:0] in_size;
	logic                 accept;
	logic [SIZE_BITS-1:0] entry;
	logic                 active;
	logic                 better;
	logic                 out_free;
	logic [SIZE_BITS-1:0] remain;

	assign in_idx  = s_tdata[IDX_W-1:0];
	assign in_size = s_tdata[IDX_W+SIZE_BITS-1:IDX_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// The shared compare unit: one table entry per scan cycle. Entries at or
	// above block_count do not take part; a strict greater-than keeps the
	// lowest index on a tie.
	assign entry  = table_q[scan_q];
	assign active = {1'b0, scan_q} < block_count_q;
	assign better = active && (entry >= size_q) && (!found_q || (entry > best_val_q));

	assign out_free = !m_tvalid_q || m_tready;
	assign remain   = best_val_q - size_q;

	// Configuration register. The sender writes it only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= CNT_W'(NUM_BLOCKS);
		end else if (cfg_we) begin
			block_count_q <= cfg_wdata;
		end
	end

	// Free-size table. A load writes on acceptance; a successful allocation
	// writes back the reduced size when its result is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				table_q[i] <= '0;
			end
		end else if (accept && (s_tuser == CMD_LOAD)) begin
			table_q[in_idx] <= in_size;
		end else if ((state_q == ST_RESP) && out_free && (cmd_q == CMD_ALLOC) && found_q) begin
			table_q[best_idx_q] <= remain;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_LOAD;
			idx_q       <= '0;
			size_q      <= '0;
			last_q      <= 1'b0;
			scan_q      <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_val_q  <= '0;
			m_tvalid_q  <= 1'b0;
			m_granted_q <= 1'b0;
			m_idx_q     <= '0;
			m_size_q    <= '0;
			m_last_q    <= 1'b0;
		end else begin
			// Outside the response state a taken result simply leaves the
			// output register; in it the register is reloaded instead.
			if (m_tready && (state_q != ST_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q      <= s_tuser;
						idx_q      <= in_idx;
						size_q     <= in_size;
						last_q     <= s_tlast;
						scan_q     <= '0;
						found_q    <= 1'b0;
						best_idx_q <= '0;
						best_val_q <= '0;
						state_q    <= (s_tuser == CMD_ALLOC) ? ST_SCAN : ST_RESP;
					end
				end
				ST_SCAN: begin
					if (better) begin
						found_q    <= 1'b1;
						best_idx_q <= scan_q;
						best_val_q <= entry;
					end
					if (scan_q == IDX_W'(NUM_BLOCKS - 1)) begin
						state_q <= ST_RESP;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_last_q   <= last_q;
						if (cmd_q == CMD_LOAD) begin
							m_granted_q <= 1'b1;
							m_idx_q     <= idx_q;
							m_size_q    <= size_q;
						end else if (found_q) begin
							m_granted_q <= 1'b1;
							m_idx_q     <= best_idx_q;
							m_size_q    <= remain;
						end else begin
							// No block is large enough: report a refusal with zero index and size.
							m_granted_q <= 1'b0;
							m_idx_q     <= '0;
							m_size_q    <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_granted_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_size_q, m_idx_q};

endmodule

// ===== rtl/wfba_checker.sv =====
// Port-level checker for the worst-fit block allocator, bound to the top level.
// Depends on wfba_pkg and worst_fit_block_allocator_top.
module wfba_checker
	import wfba_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic [CNT_W-1:0]  cfg_wdata,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [DATA_W-1:0] s_tdata,
	input logic              s_tuser,
	input logic              s_tlast,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic              m_tuser,
	input logic              m_tlast
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled result changed");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready straight after an accepted item");

	// A refused allocation carries a zero index and size.
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0))
		else $error("refused allocation with non-zero payload");

	// A new result is only issued while the input side is busy.
	a_new_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result issued without an item in progress");

endmodule

bind worst_fit_block_allocator_top wfba_checker u_wfba_checker (.*);
